>>> hw/rtl/assert_macros.svh
// Assertion macros for the arpeggiator RTL.
// Depends on nothing; each macro expects signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/na_pkg.sv
// Types, codes and constants of the note arpeggiator.
// Depends on nothing.
`timescale 1ns / 1ps

package na_pkg;

   localparam int NUM_KEYS = 128;
   localparam int KEY_W    = $clog2(NUM_KEYS);

   localparam logic [2:0] OP_NOTE_ON  = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF = 3'd1;
   localparam logic [2:0] OP_CTRL     = 3'd2;
   localparam logic [2:0] OP_CLOCK    = 3'd3;
   localparam logic [2:0] OP_RESET    = 3'd4;

   localparam logic [2:0] MODE_OFF    = 3'd0;
   localparam logic [2:0] MODE_UP     = 3'd1;
   localparam logic [2:0] MODE_DOWN   = 3'd2;
   localparam logic [2:0] MODE_UPDOWN = 3'd3;
   localparam logic [2:0] MODE_RANDOM = 3'd4;

   localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
   localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
   localparam logic [1:0] KIND_PEDAL    = 2'd2;
   localparam logic [1:0] KIND_THROUGH  = 2'd3;

   localparam logic [6:0] CC_HOLD    = 7'd64;
   localparam logic [6:0] CC_ALL_OFF = 7'd123;
   localparam logic [6:0] VEL_MID    = 7'd64;
   localparam logic [8:0] NOTE_MAX   = 9'd127;
   localparam logic [8:0] OCT_STEP   = 9'd12;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_SPAN = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] note;
      logic [6:0] value;
      logic       level;
      logic [2:0] random_steps;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] out_note;
      logic [6:0] out_value;
      logic [2:0] through_op;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] arp_mode;
      logic [3:0] octave_span;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_PEDAL, ST_OFF, ST_ADV, ST_SCAN, ST_POST,
      ST_RMOD, ST_PLAY, ST_FOLD, ST_THRU, ST_FLUSH
   } state_type;

   function automatic logic [2:0] eff_mode(input logic [2:0] m);
      return (m > MODE_RANDOM) ? MODE_OFF : m;
   endfunction

endpackage

>>> hw/rtl/na_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module na_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/na_core.sv
// Sequencer of the arpeggiator: key maps, a shared one-key-per-cycle scan
// step, octave arithmetic and the result register. Depends on na_pkg, na_ram.
`timescale 1ns / 1ps

module na_core (
   input  logic            clock,
   input  logic            reset,
   input  na_pkg::cfg_type cfg,
   input  logic            req_valid,
   output logic            req_ready,
   input  na_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output na_pkg::rsp_type rsp_data
);
   import na_pkg::*;
   `include "assert_macros.svh"

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   rsp_type   pend_ff, pend_in, rsp_ff, rsp_in, emit_data;
   logic      pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;
   logic [NUM_KEYS-1:0] sounding_ff, sounding_in, pressed_ff, pressed_in;
   logic [NUM_KEYS-1:0] vel_ok_ff, vel_ok_in;
   logic [KEY_W-1:0] seq_key_ff, seq_key_in, nk_ff, nk_in, k_next;
   logic [3:0] oct_ff, oct_in;
   logic [6:0] active_note_ff, active_note_in;
   logic active_valid_ff, active_valid_in, going_up_ff, going_up_in;
   logic pedal_in_ff, pedal_in_in, pedal_out_ff, pedal_out_in;
   logic clock_high_ff, clock_high_in, dir_ff, dir_in;
   logic [1:0] retry_ff, retry_in;
   logic [2:0] step_ff, step_in;
   logic [4:0] rmod_ff, rmod_in;
   logic [8:0] fold_ff, fold_in;
   logic f_ped_ff, f_ped_in, f_off_ff, f_off_in, f_adv_ff, f_adv_in;
   logic f_thru_ff, f_thru_in;
   logic [2:0] mode;
   logic emit_req, out_free, can_emit, emit_fire, in_range, clean, new_pedal;
   logic ram_we;
   logic [6:0] ram_q, vel;
   state_type after_off, after_adv;

   na_ram #(.WIDTH(7), .DEPTH(NUM_KEYS)) u_vel_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(item_ff.note[KEY_W-1:0]),
      .wr_data(item_ff.value),
      .rd_addr(nk_ff),
      .rd_data(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         sounding_ff     <= '0;
         pressed_ff      <= '0;
         vel_ok_ff       <= '0;
         seq_key_ff      <= '0;
         oct_ff          <= '0;
         active_valid_ff <= 1'b0;
         going_up_ff     <= 1'b1;
         pedal_in_ff     <= 1'b0;
         pedal_out_ff    <= 1'b0;
         clock_high_ff   <= 1'b0;
         f_ped_ff        <= 1'b0;
         f_off_ff        <= 1'b0;
         f_adv_ff        <= 1'b0;
         f_thru_ff       <= 1'b0;
         retry_ff        <= '0;
         step_ff         <= '0;
         dir_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         sounding_ff     <= sounding_in;
         pressed_ff      <= pressed_in;
         vel_ok_ff       <= vel_ok_in;
         seq_key_ff      <= seq_key_in;
         oct_ff          <= oct_in;
         active_valid_ff <= active_valid_in;
         going_up_ff     <= going_up_in;
         pedal_in_ff     <= pedal_in_in;
         pedal_out_ff    <= pedal_out_in;
         clock_high_ff   <= clock_high_in;
         f_ped_ff        <= f_ped_in;
         f_off_ff        <= f_off_in;
         f_adv_ff        <= f_adv_in;
         f_thru_ff       <= f_thru_in;
         retry_ff        <= retry_in;
         step_ff         <= step_in;
         dir_ff          <= dir_in;
      end
      item_ff        <= item_in;
      pend_ff        <= pend_in;
      rsp_ff         <= rsp_in;
      nk_ff          <= nk_in;
      active_note_ff <= active_note_in;
      rmod_ff        <= rmod_in;
      fold_ff        <= fold_in;
   end

   always_comb begin
      mode      = eff_mode(cfg.arp_mode);
      out_free  = !rsp_valid_ff || rsp_ready;
      can_emit  = !pend_valid_ff || out_free;
      in_range  = {1'b0, item_ff.note} < 8'(NUM_KEYS);
      clean     = !(|pressed_ff);
      new_pedal = item_ff.value >= VEL_MID;
      vel       = vel_ok_ff[nk_ff] ? ram_q : VEL_MID;
      k_next    = dir_ff ? ((nk_ff == KEY_W'(NUM_KEYS - 1)) ? '0 : nk_ff + 1'b1)
                         : ((nk_ff == '0) ? KEY_W'(NUM_KEYS - 1) : nk_ff - 1'b1);
      after_adv = f_thru_ff ? ST_THRU : ST_FLUSH;
      after_off = f_adv_ff ? ST_ADV : after_adv;

      state_in        = state_ff;
      item_in         = item_ff;
      pend_in         = pend_ff;
      pend_valid_in   = pend_valid_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_ready ? 1'b0 : rsp_valid_ff;
      sounding_in     = sounding_ff;
      pressed_in      = pressed_ff;
      vel_ok_in       = vel_ok_ff;
      seq_key_in      = seq_key_ff;
      nk_in           = nk_ff;
      oct_in          = oct_ff;
      active_note_in  = active_note_ff;
      active_valid_in = active_valid_ff;
      going_up_in     = going_up_ff;
      pedal_in_in     = pedal_in_ff;
      pedal_out_in    = pedal_out_ff;
      clock_high_in   = clock_high_ff;
      dir_in          = dir_ff;
      retry_in        = retry_ff;
      step_in         = step_ff;
      rmod_in         = rmod_ff;
      fold_in         = fold_ff;
      f_ped_in        = f_ped_ff;
      f_off_in        = f_off_ff;
      f_adv_in        = f_adv_ff;
      f_thru_in       = f_thru_ff;
      ram_we          = 1'b0;
      req_ready       = 1'b0;
      emit_req        = 1'b0;
      emit_data       = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            f_ped_in  = 1'b0;
            f_off_in  = 1'b0;
            f_adv_in  = 1'b0;
            f_thru_in = 1'b0;
            case (item_ff.op)
               OP_NOTE_ON: begin
                  if (clean) begin
                     seq_key_in = (mode == MODE_DOWN) ? KEY_W'(NUM_KEYS - 1) : '0;
                     oct_in     = (mode == MODE_DOWN) ? cfg.octave_span : '0;
                     if (pedal_in_ff) begin
                        sounding_in = '0;
                        pressed_in  = '0;
                     end
                  end
                  if (in_range) begin
                     sounding_in[item_ff.note[KEY_W-1:0]] = 1'b1;
                     pressed_in[item_ff.note[KEY_W-1:0]]  = 1'b1;
                     vel_ok_in[item_ff.note[KEY_W-1:0]]   = 1'b1;
                     ram_we = 1'b1;
                  end
                  f_off_in  = clean && clock_high_ff;
                  f_adv_in  = clean && clock_high_ff;
                  f_thru_in = (mode == MODE_OFF);
               end
               OP_NOTE_OFF: begin
                  if (in_range) begin
                     if (!pedal_in_ff || mode == MODE_OFF) begin
                        sounding_in[item_ff.note[KEY_W-1:0]] = 1'b0;
                     end
                     pressed_in[item_ff.note[KEY_W-1:0]] = 1'b0;
                  end
                  f_thru_in = (mode == MODE_OFF);
               end
               OP_CTRL: begin
                  f_thru_in = 1'b1;
                  if (item_ff.note == CC_ALL_OFF) begin
                     f_off_in    = 1'b1;
                     sounding_in = '0;
                     pressed_in  = '0;
                  end
                  if (item_ff.note == CC_HOLD) begin
                     f_thru_in   = (mode == MODE_OFF);
                     pedal_in_in = new_pedal;
                     if (mode == MODE_OFF) begin
                        if (new_pedal != pedal_out_ff) begin
                           pedal_out_in = new_pedal;
                           f_ped_in     = 1'b1;
                        end
                     end else if (pedal_in_ff && !new_pedal) begin
                        f_off_in    = 1'b1;
                        sounding_in = sounding_ff & pressed_ff;
                     end
                  end
               end
               OP_CLOCK: begin
                  clock_high_in = item_ff.level;
                  f_adv_in      = (mode != MODE_OFF);
               end
               OP_RESET: begin
                  seq_key_in = (mode == MODE_DOWN) ? KEY_W'(NUM_KEYS - 1) : '0;
                  oct_in     = (mode == MODE_DOWN) ? cfg.octave_span : '0;
                  f_off_in   = clock_high_ff;
                  f_adv_in   = clock_high_ff;
               end
               default: begin
                  f_thru_in = 1'b1;
               end
            endcase
            state_in = ST_PEDAL;
         end
         ST_PEDAL: begin
            if (f_ped_ff) begin
               emit_req  = 1'b1;
               emit_data = '{KIND_PEDAL, CC_HOLD, {6'd0, pedal_out_ff}, 3'd0, 1'b0};
               if (can_emit) begin
                  state_in = ST_OFF;
               end
            end else begin
               state_in = ST_OFF;
            end
         end
         ST_OFF: begin
            if (f_off_ff && active_valid_ff) begin
               emit_req  = 1'b1;
               emit_data = '{KIND_NOTE_OFF, active_note_ff, VEL_MID, 3'd0, 1'b0};
               if (can_emit) begin
                  active_valid_in = 1'b0;
                  state_in        = after_off;
               end
            end else begin
               state_in = after_off;
            end
         end
         ST_ADV: begin
            if (!clock_high_ff) begin
               if (active_valid_ff) begin
                  emit_req  = 1'b1;
                  emit_data = '{KIND_NOTE_OFF, active_note_ff, VEL_MID, 3'd0, 1'b0};
                  if (can_emit) begin
                     active_valid_in = 1'b0;
                     state_in        = after_adv;
                  end
               end else begin
                  state_in = after_adv;
               end
            end else begin
               nk_in    = seq_key_ff;
               retry_in = 2'd2;
               step_in  = item_ff.random_steps;
               case (mode)
                  MODE_UP: begin
                     dir_in   = 1'b1;
                     state_in = ST_SCAN;
                  end
                  MODE_DOWN, MODE_RANDOM: begin
                     dir_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
                  MODE_UPDOWN: begin
                     dir_in   = going_up_ff;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_PLAY;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            nk_in = k_next;
            if (sounding_ff[k_next] || k_next == seq_key_ff) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            state_in = ST_PLAY;
            case (mode)
               MODE_UP: begin
                  if (nk_ff <= seq_key_ff) begin
                     oct_in = (oct_ff >= cfg.octave_span) ? 4'd0 : oct_ff + 4'd1;
                  end
               end
               MODE_DOWN: begin
                  if (nk_ff >= seq_key_ff) begin
                     oct_in = (oct_ff == 4'd0) ? cfg.octave_span : oct_ff - 4'd1;
                  end
               end
               MODE_UPDOWN: begin
                  if (going_up_ff) begin
                     if (nk_ff <= seq_key_ff) begin
                        if (oct_ff >= cfg.octave_span) begin
                           nk_in       = seq_key_ff;
                           going_up_in = 1'b0;
                           dir_in      = 1'b0;
                           retry_in    = retry_ff - 2'd1;
                           if (retry_ff != 2'd1) begin
                              state_in = ST_SCAN;
                           end
                        end else begin
                           oct_in = oct_ff + 4'd1;
                        end
                     end
                  end else begin
                     if (nk_ff >= seq_key_ff) begin
                        if (oct_ff == 4'd0) begin
                           nk_in       = seq_key_ff;
                           going_up_in = 1'b1;
                           dir_in      = 1'b1;
                           retry_in    = retry_ff - 2'd1;
                           if (retry_ff != 2'd1) begin
                              state_in = ST_SCAN;
                           end
                        end else begin
                           oct_in = oct_ff - 4'd1;
                        end
                     end
                  end
               end
               MODE_RANDOM: begin
                  seq_key_in = nk_ff;
                  if (step_ff == 3'd0) begin
                     rmod_in  = {1'b0, oct_ff} + {2'b0, item_ff.random_steps} + 5'd1;
                     state_in = ST_RMOD;
                  end else begin
                     step_in  = step_ff - 3'd1;
                     state_in = ST_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RMOD: begin
            if (rmod_ff >= {1'b0, cfg.octave_span} + 5'd1) begin
               rmod_in = rmod_ff - ({1'b0, cfg.octave_span} + 5'd1);
            end else begin
               oct_in   = rmod_ff[3:0];
               state_in = ST_PLAY;
            end
         end
         ST_PLAY: begin
            if (sounding_ff[nk_ff]) begin
               seq_key_in = nk_ff;
               fold_in    = 9'(nk_ff) + 9'(oct_ff) * OCT_STEP;
               state_in   = ST_FOLD;
            end else begin
               seq_key_in = (mode == MODE_DOWN) ? KEY_W'(NUM_KEYS - 1) : '0;
               oct_in     = (mode == MODE_DOWN) ? cfg.octave_span : '0;
               state_in   = after_adv;
            end
         end
         ST_FOLD: begin
            if (fold_ff > NOTE_MAX) begin
               fold_in = fold_ff - OCT_STEP;
            end else begin
               emit_req  = 1'b1;
               emit_data = '{KIND_NOTE_ON, fold_ff[6:0], vel, 3'd0, 1'b0};
               if (can_emit) begin
                  active_note_in  = fold_ff[6:0];
                  active_valid_in = 1'b1;
                  state_in        = after_adv;
               end
            end
         end
         ST_THRU: begin
            emit_req  = 1'b1;
            emit_data = '{KIND_THROUGH, item_ff.note, item_ff.value, item_ff.op, 1'b0};
            if (can_emit) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      emit_fire = emit_req && can_emit;
      if (emit_fire) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_in.last  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = emit_data;
         pend_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_SAME(a_idle_no_pending, state_ff == ST_IDLE, !pend_valid_ff, "pending item in idle")
   `ASSERT_NEXT(a_accept_dispatch, req_valid && req_ready, state_ff == ST_DISPATCH,
                "accepted item not dispatched")
   `ASSERT_NEXT(a_flush_done, state_ff == ST_FLUSH && out_free, state_ff == ST_IDLE,
                "flush did not complete")

endmodule

>>> hw/rtl/note_arpeggiator.sv
// Top level of the note arpeggiator: configuration registers and the core.
// Depends on na_pkg, na_core.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_data (req_type)
//   rsp       out        rsp_valid/rsp_ready  rsp_data (rsp_type)
//   csr       in         psel/penable/pready  paddr, pwdata, prdata
//
// An item visits keys one per cycle in the shared scan step, up to NUM_KEYS
// keys per scan, and random mode runs up to eight scans per item.
// Reset is synchronous and clears all key maps at once; no clearing pass.
// A stalled result holds the sequencer only when a further result is ready.
`timescale 1ns / 1ps

module note_arpeggiator (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  na_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output na_pkg::rsp_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);
   import na_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr)
            REG_MODE: cfg_in.arp_mode    = pwdata[2:0];
            REG_SPAN: cfg_in.octave_span = pwdata[3:0];
            default: begin
            end
         endcase
      end
      case (paddr)
         REG_MODE: prdata = {29'd0, cfg_ff.arp_mode};
         REG_SPAN: prdata = {28'd0, cfg_ff.octave_span};
         default:  prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   na_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
